@@ hw/rtl/element_ring_buffer_unit_defines.svh @@
// Assertion macros shared by the ring buffer RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ELEMENT_RING_BUFFER_UNIT_DEFINES_SVH
`define ELEMENT_RING_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication
`define ERB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ring buffer check failed");

// next-cycle implication
`define ERB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ring buffer check failed");

`endif

@@ hw/rtl/erb_pkg.sv @@
// Shared types and constants of the element ring buffer.
// No dependencies.
`timescale 1ns / 1ps
package erb_pkg;

	localparam int STORE_BYTES       = 1024;
	localparam int MAX_ELEMENT_BYTES = 8;
	localparam int BYTE_W            = 8;
	localparam int DATA_W            = BYTE_W * MAX_ELEMENT_BYTES;
	localparam int POS_W             = $clog2(STORE_BYTES);
	localparam int CAP_W             = 11;
	localparam int ESZ_W             = 4;
	localparam int IDX_W             = (MAX_ELEMENT_BYTES > 1) ? $clog2(MAX_ELEMENT_BYTES) : 1;
	localparam int CFG_IDX_W         = 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
	localparam logic [ESZ_W-1:0] ESZ_RESET = ESZ_W'(1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT  = 1'b1;

	// item commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [DATA_W-1:0] element_data;
		logic              last_in_call;
	} in_item_t;

	typedef struct packed {
		logic              done_res;
		logic [DATA_W-1:0] read_data;
		logic [CAP_W-1:0]  call_count;
		logic [CAP_W-1:0]  stored_bytes;
		logic              is_full;
		logic              is_empty;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_PUBLISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic wr_step;
		logic rd_step;
		logic drain;
		logic publish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic acc_ok;
		logic acc_read;
		logic last_byte;
		logic out_free;
	} dp_status_t;

endpackage

@@ hw/rtl/erb_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module erb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/erb_ctrl.sv @@
// Sequencer of the ring buffer: accept, byte steps, read drain, publish.
// Depends on erb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "element_ring_buffer_unit_defines.svh"
module erb_ctrl
	import erb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!status.acc_ok) state_nx = ST_PUBLISH;
					else if (status.acc_read) state_nx = ST_READ;
					else state_nx = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (status.last_byte) state_nx = ST_PUBLISH;
			end
			ST_READ: begin
				if (status.last_byte) state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nx = ST_PUBLISH;
			end
			ST_PUBLISH: begin
				if (status.out_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_WRITE:   cmd.wr_step = 1'b1;
			ST_READ:    cmd.rd_step = 1'b1;
			ST_DRAIN:   cmd.drain   = 1'b1;
			ST_PUBLISH: cmd.publish = status.out_free;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// a result waiting on a busy output slot keeps the sequencer parked
	`ERB_ASSERT_NEXT(a_publish_hold, state_q == ST_PUBLISH && !status.out_free, state_q == ST_PUBLISH)
	// the drain step only ever follows the byte steps of a read
	`ERB_ASSERT_NOW(a_drain_after_read, state_q == ST_DRAIN, $past(state_q) == ST_READ)

endmodule

@@ hw/rtl/erb_datapath.sv @@
// Ring buffer datapath: positions, byte store, item and result registers.
// Depends on erb_pkg, erb_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "element_ring_buffer_unit_defines.svh"
module erb_datapath
	import erb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data,
	input  in_item_t             in_item,
	output out_item_t            out_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  dp_cmd_t              cmd,
	output dp_status_t           status
);

	localparam logic [CAP_W-1:0] COUNT_MAX = '1;

	logic [CAP_W-1:0]  cap_q;
	logic [ESZ_W-1:0]  esz_q;
	logic [POS_W-1:0]  wp_q, rp_q, addr_q;
	logic              empty_q;
	logic [CAP_W-1:0]  moved_q;

	logic              cmd_q, last_q, ok_q;
	logic [DATA_W-1:0] data_q, rdata_q;
	logic [IDX_W-1:0]  idx_q, idx_s1;
	logic              rd_valid_s1;
	logic [BYTE_W-1:0] ram_rdata;

	out_item_t         out_q;
	logic              out_valid_q;

	logic [CAP_W-1:0]  cap_eff, held, free_bytes, addr_inc, moved_nx;
	logic [ESZ_W-1:0]  esz_eff;
	logic [POS_W-1:0]  addr_nx;
	logic              wr_ok, rd_ok;

	// out-of-range register values are clamped
	always_comb begin
		if (cap_q == '0) cap_eff = CAP_W'(1);
		else if (cap_q > CAP_W'(STORE_BYTES)) cap_eff = CAP_W'(STORE_BYTES);
		else cap_eff = cap_q;
		if (esz_q == '0) esz_eff = ESZ_W'(1);
		else if (esz_q > ESZ_W'(MAX_ELEMENT_BYTES)) esz_eff = ESZ_W'(MAX_ELEMENT_BYTES);
		else esz_eff = esz_q;
	end

	always_comb begin
		if (empty_q) held = '0;
		else if (wp_q > rp_q) held = CAP_W'(wp_q) - CAP_W'(rp_q);
		else if (wp_q < rp_q) held = cap_eff - (CAP_W'(rp_q) - CAP_W'(wp_q));
		else held = cap_eff;
	end

	assign free_bytes = cap_eff - held;
	assign wr_ok      = free_bytes >= CAP_W'(esz_eff);
	assign rd_ok      = !empty_q && (held >= CAP_W'(esz_eff));

	assign addr_inc = CAP_W'(addr_q) + CAP_W'(1);
	assign addr_nx  = (addr_inc == cap_eff) ? '0 : addr_inc[POS_W-1:0];

	assign moved_nx = (ok_q && moved_q != COUNT_MAX) ? moved_q + CAP_W'(1) : moved_q;

	assign status.acc_ok    = (in_item.cmd == CMD_READ) ? rd_ok : wr_ok;
	assign status.acc_read  = (in_item.cmd == CMD_READ);
	assign status.last_byte = (idx_q == IDX_W'(esz_eff - ESZ_W'(1)));
	assign status.out_free  = !out_valid_q || !out_stall;

	erb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_step),
		.waddr(addr_q),
		.wdata(data_q[idx_q*BYTE_W +: BYTE_W]),
		.re   (cmd.rd_step),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			esz_q       <= ESZ_RESET;
			wp_q        <= '0;
			rp_q        <= '0;
			empty_q     <= 1'b1;
			moved_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_step;
			if (cfg_we) begin
				case (cfg_index)
					REG_CAPACITY: cap_q <= cfg_data;
					REG_ELEMENT:  esz_q <= cfg_data[ESZ_W-1:0];
					default: begin
						cap_q <= cap_q;
					end
				endcase
				wp_q    <= '0;
				rp_q    <= '0;
				empty_q <= 1'b1;
			end else begin
				// an accepted write into an empty buffer restarts both positions
				if (cmd.load && in_item.cmd == CMD_WRITE && wr_ok && empty_q) begin
					wp_q <= '0;
					rp_q <= '0;
				end
				if (cmd.wr_step && status.last_byte) begin
					wp_q    <= addr_nx;
					empty_q <= 1'b0;
				end
				if (cmd.rd_step && status.last_byte) begin
					rp_q <= addr_nx;
				end
				if (cmd.drain && rp_q == wp_q) begin
					empty_q <= 1'b1;
				end
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
				moved_q     <= last_q ? '0 : moved_nx;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and byte registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd.load) begin
			cmd_q   <= in_item.cmd;
			data_q  <= in_item.element_data;
			last_q  <= in_item.last_in_call;
			ok_q    <= status.acc_ok;
			idx_q   <= '0;
			rdata_q <= '0;
			if (in_item.cmd == CMD_READ) addr_q <= rp_q;
			else if (empty_q) addr_q <= '0;
			else addr_q <= wp_q;
		end else if (cmd.wr_step || cmd.rd_step) begin
			idx_q  <= idx_q + IDX_W'(1);
			addr_q <= addr_nx;
		end
		if (rd_valid_s1) begin
			rdata_q[idx_s1*BYTE_W +: BYTE_W] <= ram_rdata;
		end
		if (cmd.publish) begin
			out_q.done_res     <= ok_q;
			out_q.read_data    <= (ok_q && cmd_q == CMD_READ) ? rdata_q : '0;
			out_q.call_count   <= moved_nx;
			out_q.stored_bytes <= held;
			out_q.is_full      <= !empty_q && (wp_q == rp_q);
			out_q.is_empty     <= empty_q;
		end
	end

	assign out_item  = out_q;
	assign out_valid = out_valid_q;

	`ERB_ASSERT_NOW(a_held_in_range, 1'b1, held <= cap_eff)
	`ERB_ASSERT_NOW(a_single_step, cmd.wr_step || cmd.rd_step, !(cmd.wr_step && cmd.rd_step) && ok_q)
	`ERB_ASSERT_NEXT(a_publish_shows, cmd.publish, out_valid_q)

endmodule

@@ hw/rtl/element_ring_buffer_unit.sv @@
// Top level of the element ring buffer: sequencer plus datapath.
// Depends on erb_pkg, erb_ctrl and erb_datapath.
//
//   channel   handshake             payload
//   -------   -------------------   -------------------------
//   input     in_valid / in_stall   in_item  (in_item_t)
//   output    out_valid / out_stall out_item (out_item_t)
//   config    cfg_we                cfg_index, cfg_data
//
// A write loads the item, steps once per element byte and publishes; a read also
// drains after its byte steps: the byte-wide store moves one byte per cycle and
// its registered read needs the drain step. A refused item goes from accept
// straight to publish. The output register frees the input side once a result
// is loaded; a stalled output holds the next result in the publish step. Reset
// empties the buffer, capacity 1024 and element size 1; the store is not cleared.
`timescale 1ns / 1ps
module element_ring_buffer_unit
	import erb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAP_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item
);

	dp_cmd_t    cmd;
	dp_status_t status;

	erb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	erb_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_item  (in_item),
		.out_item (out_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

endmodule
